/* sv/assert_macros.svh */
// Assertion macros shared by the codebook background subtraction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CBS_ASSERT_IMPLY(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("codebook unit: property violated");
`define CBS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("codebook unit: forbidden condition seen");
`else
`define CBS_ASSERT_IMPLY(lbl, clk, rst, prop)
`define CBS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* sv/cbs_pkg.sv */
// Package: shared codes and controller/datapath interface types.
package cbs_pkg;

   localparam logic [1:0] REQ_LEARN  = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_DETECT = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic [1:0] CSR_LEARN_BOUND = 2'd0;
   localparam logic [1:0] CSR_LOW_MARGIN  = 2'd1;
   localparam logic [1:0] CSR_HIGH_MARGIN = 2'd2;

   localparam logic [7:0] FG_FOREGROUND = 8'd255;
   localparam logic [7:0] FG_BACKGROUND = 8'd0;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic wipe;
      logic capture;
      logic load;
      logic proc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wipe_last;
      logic req_ok;
      logic scan_done;
      logic out_busy;
   } sts_type;

endpackage

/* sv/cbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cbs_ctrl.sv */
// Request sequencer: wipe after reset, pixel load, entry scan, result issue.
module cbs_ctrl
   import cbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_WIPE  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PIXRD = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_PROC  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PIXRD;
            end
         end
         ST_PIXRD: state_in = sts.req_ok ? ST_LOAD : ST_FIN;
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: state_in = sts.scan_done ? ST_FIN : ST_PROC;
         ST_PROC: begin
            cmd.proc = 1'b1;
            state_in = ST_RD;
         end
         ST_FIN: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/cbs_datapath.sv */
// Datapath: request capture, codebook stores, per-entry update logic, result register.
module cbs_datapath
   import cbs_pkg::*;
#(
   parameter int PIXELS    = 4096,
   parameter int ENTRIES   = 8,
   parameter int CHANNELS  = 3,
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wr_data
);

   localparam int PIX_W  = PIXELS > 1 ? $clog2(PIXELS) : 1;
   localparam int SLOTS  = PIXELS * ENTRIES;
   localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int CW     = $clog2(ENTRIES + 1);
   localparam int TB     = TIME_BITS;
   localparam int CB     = 8 * CHANNELS;
   localparam int LOW_O  = 0;
   localparam int HIGH_O = CB;
   localparam int MIN_O  = 2 * CB;
   localparam int MAX_O  = 3 * CB;
   localparam int LAST_O = 4 * CB;
   localparam int STL_O  = 4 * CB + TB;
   localparam int EW     = 4 * CB + 2 * TB;
   localparam int PW     = CW + TB;
   localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

   // configuration
   logic [7:0] lb_ff, lm_ff, hm_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff <= 8'd10;
         lm_ff <= 8'd3;
         hm_ff <= 8'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEARN_BOUND: lb_ff <= csr_wr_data;
            CSR_LOW_MARGIN:  lm_ff <= csr_wr_data;
            CSR_HIGH_MARGIN: hm_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // request capture
   logic [1:0]                 kind_ff;
   logic [11:0]                pix_ff;
   logic [CHANNELS-1:0][7:0]   px_ff, px_in;
   logic                       ok_ff;
   logic                       ok_in;

   always_comb begin
      for (int n = 0; n < CHANNELS; n++) begin
         if (n == 0)      px_in[n] = req_tdata[19:12];
         else if (n == 1) px_in[n] = req_tdata[27:20];
         else if (n == 2) px_in[n] = req_tdata[35:28];
         else             px_in[n] = 8'd0;
      end
      ok_in = (32'(req_tdata[11:0]) < 32'(PIXELS)) && (req_tuser != REQ_NONE);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         pix_ff  <= req_tdata[11:0];
         px_ff   <= px_in;
         ok_ff   <= ok_in;
      end
   end

   // stores
   logic [PIX_W-1:0]  wipe_ff;
   logic              pix_we;
   logic [PIX_W-1:0]  pix_waddr;
   logic [PW-1:0]     pix_wdata, pix_rdata;
   logic              ent_we;
   logic [SLOT_W-1:0] ent_waddr, ent_raddr;
   logic [EW-1:0]     ent_wdata, ent_rdata;

   cbs_ram #(.WIDTH(PW), .DEPTH(PIXELS)) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (pix_waddr),
      .wr_data (pix_wdata),
      .rd_addr (PIX_W'(pix_ff)),
      .rd_data (pix_rdata)
   );

   cbs_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff <= '0;
      end else if (cmd.wipe) begin
         wipe_ff <= wipe_ff + 1'b1;
      end
   end

   // scan state
   logic [CW-1:0] cnt_ff, e_ff, k_ff, hit_ff;
   logic [TB-1:0] clk_ff;
   logic          found_ff;
   logic [31:0]   base;

   assign base      = 32'(pix_ff) * 32'(ENTRIES);
   assign ent_raddr = SLOT_W'(base + 32'(e_ff));

   // per-channel learning window around the pixel
   logic [CHANNELS-1:0][7:0] hi_b, lo_b;
   always_comb begin
      for (int n = 0; n < CHANNELS; n++) begin
         logic [8:0] s;
         s = {1'b0, px_ff[n]} + {1'b0, lb_ff};
         hi_b[n] = s[8] ? 8'hFF : s[7:0];
         lo_b[n] = (px_ff[n] > lb_ff) ? px_ff[n] - lb_ff : 8'd0;
      end
   end

   // entry update
   logic          in_learn, in_box, keep;
   logic [EW-1:0] learn_word, clear_word, new_word;
   logic [TB-1:0] e_last, e_stale, run;
   logic          is_learn, is_clear, is_detect, make_new, full;

   assign is_learn  = (kind_ff == REQ_LEARN);
   assign is_clear  = (kind_ff == REQ_CLEAR);
   assign is_detect = (kind_ff == REQ_DETECT);

   always_comb begin
      e_last   = ent_rdata[LAST_O +: TB];
      e_stale  = ent_rdata[STL_O +: TB];
      run      = clk_ff - e_last;
      in_learn = 1'b1;
      in_box   = 1'b1;
      for (int n = 0; n < CHANNELS; n++) begin
         if (ent_rdata[LOW_O + 8*n +: 8] > px_ff[n] ||
             px_ff[n] > ent_rdata[HIGH_O + 8*n +: 8]) in_learn = 1'b0;
         if ({1'b0, px_ff[n]} + {1'b0, lm_ff} < {1'b0, ent_rdata[MIN_O + 8*n +: 8]} ||
             {1'b0, px_ff[n]} > {1'b0, ent_rdata[MAX_O + 8*n +: 8]} + {1'b0, hm_ff})
            in_box = 1'b0;
      end
      learn_word = ent_rdata;
      if (in_learn && !found_ff) begin
         learn_word[LAST_O +: TB] = clk_ff;
         for (int n = 0; n < CHANNELS; n++) begin
            if (ent_rdata[MAX_O + 8*n +: 8] < px_ff[n])
               learn_word[MAX_O + 8*n +: 8] = px_ff[n];
            else if (ent_rdata[MIN_O + 8*n +: 8] > px_ff[n])
               learn_word[MIN_O + 8*n +: 8] = px_ff[n];
            if (ent_rdata[HIGH_O + 8*n +: 8] < hi_b[n])
               learn_word[HIGH_O + 8*n +: 8] = ent_rdata[HIGH_O + 8*n +: 8] + 8'd1;
            if (ent_rdata[LOW_O + 8*n +: 8] > lo_b[n])
               learn_word[LOW_O + 8*n +: 8] = ent_rdata[LOW_O + 8*n +: 8] - 8'd1;
         end
      end else if (e_stale < run) begin
         learn_word[STL_O +: TB] = run;
      end
      keep       = (e_stale <= (clk_ff >> 1));
      clear_word = ent_rdata;
      clear_word[LAST_O +: TB] = '0;
      new_word = {{TB{1'b0}}, clk_ff, px_ff, px_ff, hi_b, lo_b};
   end

   assign full     = (cnt_ff == CW'(ENTRIES));
   assign make_new = ok_ff && is_learn && !found_ff && !full;

   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = SLOT_W'(base + 32'(e_ff));
      ent_wdata = learn_word;
      if (cmd.proc && is_learn) begin
         ent_we = 1'b1;
      end else if (cmd.proc && is_clear) begin
         ent_we    = keep;
         ent_waddr = SLOT_W'(base + 32'(k_ff));
         ent_wdata = clear_word;
      end else if (cmd.finish && make_new) begin
         ent_we    = 1'b1;
         ent_waddr = SLOT_W'(base + 32'(cnt_ff));
         ent_wdata = new_word;
      end
   end

   always_comb begin
      pix_we    = 1'b0;
      pix_waddr = PIX_W'(pix_ff);
      pix_wdata = {clk_ff, cnt_ff};
      if (cmd.wipe) begin
         pix_we    = 1'b1;
         pix_waddr = wipe_ff;
         pix_wdata = '0;
      end else if (cmd.finish && ok_ff && is_learn) begin
         pix_we    = 1'b1;
         pix_wdata = {clk_ff, make_new ? cnt_ff + 1'b1 : cnt_ff};
      end else if (cmd.finish && ok_ff && is_clear) begin
         pix_we    = 1'b1;
         pix_wdata = {{TB{1'b0}}, k_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff   <= pix_rdata[CW-1:0];
         clk_ff   <= (is_learn && pix_rdata[CW +: TB] < TIME_MAX) ?
                     pix_rdata[CW +: TB] + 1'b1 : pix_rdata[CW +: TB];
         e_ff     <= '0;
         k_ff     <= '0;
         hit_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.proc) begin
         e_ff <= e_ff + 1'b1;
         if (is_clear && keep) k_ff <= k_ff + 1'b1;
         if (is_learn && in_learn && !found_ff) begin
            found_ff <= 1'b1;
            hit_ff   <= e_ff;
         end
         if (is_detect && in_box) found_ff <= 1'b1;
      end
   end

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [7:0] fg;
      logic [2:0] slot;
      logic       bf;
      logic [3:0] drop;
      fg   = FG_BACKGROUND;
      slot = 3'd0;
      bf   = 1'b0;
      drop = 4'd0;
      if (ok_ff && is_detect) fg = found_ff ? FG_BACKGROUND : FG_FOREGROUND;
      if (ok_ff && is_learn) begin
         if (found_ff)  slot = 3'(hit_ff);
         else if (full) bf   = 1'b1;
         else           slot = 3'(cnt_ff);
      end
      if (ok_ff && is_clear) drop = 4'(cnt_ff - k_ff);
      rsp_data_in = {drop, bf, slot, fg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign sts.wipe_last = (wipe_ff == PIX_W'(PIXELS - 1));
   assign sts.req_ok    = ok_ff;
   assign sts.scan_done = (e_ff == cnt_ff);
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

/* sv/codebook_background_subtraction_unit.sv */
// Top level of the per-pixel codebook background subtraction unit.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser: req_type; tdata: pixel, R, G, B
//  rsp     | out | rsp_tvalid/tready  | tdata: fg_mask, entry_slot, book_full, dropped
//  csr     | in  | csr_wr_en          | csr_index, csr_wr_data (no read-back)
//
// A transaction scans the entries held for that pixel one after another:
// each entry is read then updated through the single port pair of the entry
// RAM. A request with an unused code or an out-of-range pixel skips the scan.
// After reset a wipe pass zeroes the per-pixel count/time store with
// req_tready low; CSR writes are taken throughout.
// One request is worked at a time; the next is accepted while a result still
// waits in the output register. A result held by rsp_tready low stalls the
// following request in its final cycle.
`include "assert_macros.svh"
module codebook_background_subtraction_unit
   import cbs_pkg::*;
#(
   parameter int PIXELS    = 4096,
   parameter int ENTRIES   = 8,
   parameter int CHANNELS  = 3,
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // [1:0] req_type
   // pixel_index[11:0], chan_red, chan_green, chan_blue, pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fg_mask[7:0], entry_slot[10:8], book_full[11], dropped_count[15:12]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   cbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbs_datapath #(
      .PIXELS    (PIXELS),
      .ENTRIES   (ENTRIES),
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // no request taken while the wipe pass runs
   `CBS_ASSERT_NEVER(a_no_req_in_wipe, clock, reset, cmd.wipe && req_tready)
   // a result is only loaded when the output register is free
   `CBS_ASSERT_IMPLY(a_fin_out_free, clock, reset, cmd.finish |-> !sts.out_busy)
   // an entry update never runs past the pixel's entry count
   `CBS_ASSERT_IMPLY(a_proc_in_range, clock, reset, cmd.proc |-> !sts.scan_done)
   // a finished result shows up as valid in the next cycle
   `CBS_ASSERT_IMPLY(a_fin_valid, clock, reset, cmd.finish |=> rsp_tvalid)

endmodule
